// ===== rtl/cbq_pkg.sv =====
// Package for the cascaded biquad IIR filter.
// Holds shared widths, codes, rounding constants and control types.
// No dependencies; cbq_mac and the top level import it.
package cbq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int NS_W      = 4;
  localparam int SEC_IDX_W = 3;
  localparam int WHICH_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SEC_SH    = 14;
  localparam int OUT_SH    = 24;

  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  localparam logic [WHICH_W-1:0] COEF_B1 = 2'd0;
  localparam logic [WHICH_W-1:0] COEF_B2 = 2'd1;
  localparam logic [WHICH_W-1:0] COEF_A1 = 2'd2;
  localparam logic [WHICH_W-1:0] COEF_A2 = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SECTIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 2'd1;

  localparam logic [NS_W-1:0] NS_RESET = 4'd1;
  localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd16777216;

  localparam logic signed [ACC_W-1:0] SEC_RND = 64'sd8192;
  localparam logic signed [ACC_W-1:0] OUT_RND = 64'sd8388608;
  localparam logic signed [ACC_W-1:0] SEC_HI  = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SEC_LO  = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] OUT_HI  = 64'sd32767;
  localparam logic signed [ACC_W-1:0] OUT_LO  = -64'sd32768;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WB,
    S_OMUL,
    S_ORND
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    logic    mul_neg;
    acc_op_t acc_op;
    logic    out_mode;
  } mac_ctl_t;

endpackage

// ===== rtl/cbq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cbq_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation.
// One 32x32 multiplier feeds a 64-bit accumulator; depends on cbq_pkg.
module cbq_mac (
  input  logic                                 clk,
  input  cbq_pkg::mac_ctl_t                    ctl,
  input  logic signed [cbq_pkg::DATA_W-1:0]    op_a,
  input  logic signed [cbq_pkg::DATA_W-1:0]    op_b,
  input  logic signed [cbq_pkg::DATA_W-1:0]    init_x,
  output logic signed [cbq_pkg::DATA_W-1:0]    sec_y,
  output logic                                 sec_sat,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  out_y,
  output logic                                 out_sat
);
  import cbq_pkg::*;

  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] sec_sh;
  logic signed [ACC_W-1:0] out_sh;
  logic signed [ACC_W-1:0] init_ext;

  assign init_ext = {{(ACC_W-DATA_W){init_x[DATA_W-1]}}, init_x};
  assign sum      = acc_r + (neg_r ? -prod_r : prod_r);
  assign sec_sh   = sum >>> SEC_SH;
  assign out_sh   = sum >>> OUT_SH;

  always_comb begin
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    if (ctl.mul_en) begin
      prod_nxt = op_a * op_b;
      neg_nxt  = ctl.mul_neg;
    end
  end

  always_comb begin
    case (ctl.acc_op)
      ACC_INIT: acc_nxt = ctl.out_mode ? OUT_RND : (init_ext <<< SEC_SH) + SEC_RND;
      ACC_ADD:  acc_nxt = sum;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    sec_sat = 1'b1;
    if (sec_sh > SEC_HI) begin
      sec_y = SEC_HI[DATA_W-1:0];
    end else if (sec_sh < SEC_LO) begin
      sec_y = SEC_LO[DATA_W-1:0];
    end else begin
      sec_y   = sec_sh[DATA_W-1:0];
      sec_sat = 1'b0;
    end
  end

  always_comb begin
    out_sat = 1'b1;
    if (out_sh > OUT_HI) begin
      out_y = OUT_HI[SAMPLE_W-1:0];
    end else if (out_sh < OUT_LO) begin
      out_y = OUT_LO[SAMPLE_W-1:0];
    end else begin
      out_y   = out_sh[SAMPLE_W-1:0];
      out_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

// ===== rtl/cascade_biquad_iir_filter.sv =====
// Top level of the cascaded direct form 1 biquad IIR filter.
// Uses cbq_pkg, cbq_ram for coefficient and history storage, cbq_mac for arithmetic.
//
// The input channel carries either a coefficient load (func 1) or a sample
// to filter (func 0). A load gives no result. A sample runs through the
// active sections one after another on a single shared multiply-accumulate
// unit: each section has four product steps and one write-back step, and
// the final output scaling has two steps (scale multiply, then round).
// The result is loaded into the output register at the same edge at which
// in_ready rises; no new item is taken while a sample is in flight. The
// shared multiplier and the one-read coefficient memory port are why the
// sections and their products run one after another.
// The output register holds a result until the receiver takes it; a new
// item may be transferred meanwhile, and only a sample that finishes while
// the previous result still waits is held back until the receiver drains.
// Configuration writes take effect at once and are meant for idle periods.
// After reset all coefficients and history read as zero through valid
// bits, so no clearing pass is needed; num_sections is 1 and output_scale 1.0.
module cascade_biquad_iir_filter #(
  parameter int MAX_SECTIONS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  logic [cbq_pkg::SEC_IDX_W-1:0]         in_coef_section,
  input  logic [cbq_pkg::WHICH_W-1:0]           in_coef_which,
  input  logic signed [cbq_pkg::COEF_W-1:0]     in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]   out_sample_out,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cbq_pkg::DATA_W-1:0]            cfg_wdata
);
  import cbq_pkg::*;

  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int COEF_DEPTH = 4 * MAX_SECTIONS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int HIST_W     = 2 * DATA_W;

  state_t state_r, state_nxt;
  logic [SEC_W-1:0]   j_r, j_nxt, last_r, last_nxt, j_inc;
  logic [WHICH_W-1:0] k_r, k_nxt;
  logic signed [DATA_W-1:0]   x0_r, x0_nxt, x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [SAMPLE_W-1:0] ih0_r, ih0_nxt, ih1_r, ih1_nxt;
  logic sat_r, sat_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic out_sat_r, out_sat_nxt;
  logic [NS_W-1:0] num_sections_r;
  logic signed [DATA_W-1:0] output_scale_r;
  logic [COEF_DEPTH-1:0]   coef_vld_r;
  logic [MAX_SECTIONS-1:0] hist_vld_r;
  logic coef_rv_r, hist_rv_r;

  logic accept_in, accept_smp, accept_load, can_out;
  logic            coef_we, coef_re;
  logic [CA_W-1:0] coef_waddr, coef_raddr;
  logic [COEF_W-1:0] coef_rdata;
  logic             hist_we, hist_re;
  logic [SEC_W-1:0] hist_raddr;
  logic [HIST_W-1:0] hist_wdata, hist_rdata;
  logic signed [DATA_W-1:0] coef_word, hist_y1, hist_y2;
  logic signed [DATA_W-1:0] op_a, op_b;
  mac_ctl_t mac_ctl;
  logic signed [DATA_W-1:0]   sec_y;
  logic                       sec_sat;
  logic signed [SAMPLE_W-1:0] out_y;
  logic                       out_sat;

  assign in_ready    = (state_r == S_IDLE);
  assign accept_in   = in_valid && in_ready;
  assign accept_smp  = accept_in && (in_func == FUNC_FILTER);
  assign accept_load = accept_in && (in_func == FUNC_LOAD) &&
                       (int'(in_coef_section) < MAX_SECTIONS);
  assign can_out     = !out_valid_r || out_ready;
  assign j_inc       = j_r + 1'b1;

  assign coef_we    = accept_load;
  assign coef_waddr = CA_W'({in_coef_section, in_coef_which});
  assign hist_wdata = {hist_y1, sec_y};

  assign coef_word = coef_rv_r ?
      {{(DATA_W-COEF_W){coef_rdata[COEF_W-1]}}, coef_rdata} : '0;
  assign hist_y1 = hist_rv_r ? hist_rdata[DATA_W-1:0] : '0;
  assign hist_y2 = hist_rv_r ? hist_rdata[HIST_W-1:DATA_W] : '0;

  cbq_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  cbq_ram #(.WIDTH(HIST_W), .DEPTH(MAX_SECTIONS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (j_r),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  cbq_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (op_a),
    .op_b    (op_b),
    .init_x  (x0_r),
    .sec_y   (sec_y),
    .sec_sat (sec_sat),
    .out_y   (out_y),
    .out_sat (out_sat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept_smp) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (k_r == COEF_A2) state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = (j_r == last_r) ? S_OMUL : S_MUL;
      end
      S_OMUL: state_nxt = S_ORND;
      S_ORND: begin
        if (can_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    coef_re    = 1'b0;
    coef_raddr = '0;
    hist_re    = 1'b0;
    hist_raddr = '0;
    hist_we    = 1'b0;
    mac_ctl    = '{mul_en: 1'b0, mul_neg: 1'b0, acc_op: ACC_HOLD, out_mode: 1'b0};
    op_a       = coef_word;
    op_b       = x1_r;
    case (state_r)
      S_IDLE: begin
        if (accept_smp) begin
          coef_re = 1'b1;
          hist_re = 1'b1;
        end
      end
      S_MUL: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.mul_neg = (k_r == COEF_A1) || (k_r == COEF_A2);
        mac_ctl.acc_op  = (k_r == COEF_B1) ? ACC_INIT : ACC_ADD;
        case (k_r)
          COEF_B1: op_b = x1_r;
          COEF_B2: op_b = x2_r;
          COEF_A1: op_b = hist_y1;
          COEF_A2: op_b = hist_y2;
          default: op_b = x1_r;
        endcase
        if (k_r != COEF_A2) begin
          coef_re    = 1'b1;
          coef_raddr = CA_W'({j_r, WHICH_W'(k_r + 1'b1)});
        end
      end
      S_WB: begin
        hist_we = 1'b1;
        if (j_r != last_r) begin
          coef_re    = 1'b1;
          coef_raddr = CA_W'({j_inc, COEF_B1});
          hist_re    = 1'b1;
          hist_raddr = j_inc;
        end
      end
      S_OMUL: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_op   = ACC_INIT;
        mac_ctl.out_mode = 1'b1;
        op_a             = output_scale_r;
        op_b             = x0_r;
      end
      S_ORND: mac_ctl.out_mode = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    j_nxt          = j_r;
    k_nxt          = k_r;
    last_nxt       = last_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    ih0_nxt        = ih0_r;
    ih1_nxt        = ih1_r;
    sat_nxt        = sat_r;
    out_sample_nxt = out_sample_r;
    out_sat_nxt    = out_sat_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (accept_smp) begin
          x0_nxt  = {{(DATA_W-SAMPLE_W){in_sample_in[SAMPLE_W-1]}}, in_sample_in};
          x1_nxt  = {{(DATA_W-SAMPLE_W){ih0_r[SAMPLE_W-1]}}, ih0_r};
          x2_nxt  = {{(DATA_W-SAMPLE_W){ih1_r[SAMPLE_W-1]}}, ih1_r};
          ih1_nxt = ih0_r;
          ih0_nxt = in_sample_in;
          sat_nxt = 1'b0;
          j_nxt   = '0;
          k_nxt   = COEF_B1;
          if (num_sections_r == '0) begin
            last_nxt = '0;
          end else if (int'(num_sections_r) > MAX_SECTIONS) begin
            last_nxt = SEC_W'(MAX_SECTIONS - 1);
          end else begin
            last_nxt = SEC_W'(int'(num_sections_r) - 1);
          end
        end
      end
      S_MUL: k_nxt = k_r + 1'b1;
      S_WB: begin
        x0_nxt  = sec_y;
        x1_nxt  = hist_y1;
        x2_nxt  = hist_y2;
        sat_nxt = sat_r | sec_sat;
        if (j_r != last_r) j_nxt = j_inc;
      end
      S_ORND: begin
        if (can_out) begin
          out_sample_nxt = out_y;
          out_sat_nxt    = sat_r | out_sat;
          out_valid_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      j_r            <= '0;
      k_r            <= COEF_B1;
      last_r         <= '0;
      ih0_r          <= '0;
      ih1_r          <= '0;
      out_valid_r    <= 1'b0;
      num_sections_r <= NS_RESET;
      output_scale_r <= SCALE_RESET;
      coef_vld_r     <= '0;
      hist_vld_r     <= '0;
      coef_rv_r      <= 1'b0;
      hist_rv_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
      ih0_r       <= ih0_nxt;
      ih1_r       <= ih1_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == CFG_NUM_SECTIONS)) begin
        num_sections_r <= cfg_wdata[NS_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_OUTPUT_SCALE)) begin
        output_scale_r <= cfg_wdata;
      end
      if (coef_we) coef_vld_r[coef_waddr] <= 1'b1;
      if (hist_we) hist_vld_r[j_r] <= 1'b1;
      if (coef_re) coef_rv_r <= coef_vld_r[coef_raddr];
      if (hist_re) hist_rv_r <= hist_vld_r[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    x0_r         <= x0_nxt;
    x1_r         <= x1_nxt;
    x2_r         <= x2_nxt;
    sat_r        <= sat_nxt;
    out_sample_r <= out_sample_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  // The section counter never runs past the last active section.
  a_sec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (j_r <= last_r && int'(last_r) < MAX_SECTIONS))
    else $error("section counter out of range");

  // Coefficients are only written while no sample is in flight.
  a_coef_idle: assert property (@(posedge clk) disable iff (!rst_n)
    coef_we |-> (state_r == S_IDLE))
    else $error("coefficient write during filtering");

  // History is written once per section, only in the write-back step.
  a_hist_wb: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> (state_r == S_WB && k_r == COEF_B1))
    else $error("history write outside write-back");

  // A finished sample lands in the output register and the block goes idle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ORND && can_out) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into output register");

endmodule
